[rtl/bra_pkg.sv]
package bra_pkg;

   localparam int MaxBytes = 32;
   localparam int ByteIdxW = $clog2(MaxBytes);
   localparam int CountW = $clog2(MaxBytes + 1);
   localparam int SlotW = $clog2(MaxBytes * 8 + 1);
   localparam int QueueDepth = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic [1:0] ST_ALLOCATED = 2'd0;
   localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] ST_FREED = 2'd2;
   localparam logic [1:0] ST_FREE_REJECT = 2'd3;

   localparam logic [0:0] REG_BYTES_IN_USE = 1'd0;

   typedef struct packed {
      logic [1:0] cls;
      logic [8:0] run_length;
      logic [8:0] slot_start;
   } cmd_type;

   localparam logic [1:0] CLS_ALLOC = 2'd0;
   localparam logic [1:0] CLS_FREE = 2'd1;
   localparam logic [1:0] CLS_FAIL = 2'd2;
   localparam logic [1:0] CLS_REJECT = 2'd3;

   function automatic logic [3:0] lead_free(input logic [7:0] b);
      logic [3:0] c;
      logic hit;
      c = 4'd8;
      hit = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (!hit && b[7-k]) begin
            c = 4'(k);
            hit = 1'b1;
         end
      end
      return c;
   endfunction

   function automatic logic [3:0] trail_free(input logic [7:0] b);
      logic [3:0] c;
      logic hit;
      c = 4'd8;
      hit = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (!hit && b[k]) begin
            c = 4'(k);
            hit = 1'b1;
         end
      end
      return c;
   endfunction

endpackage

[rtl/bra_req_if.sv]
interface bra_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [8:0] run_length;
   logic [8:0] slot_start;
   modport source(output valid, operation, run_length, slot_start, input ready);
   modport sink(input valid, operation, run_length, slot_start, output ready);
endinterface

[rtl/bra_rsp_if.sv]
interface bra_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [7:0] granted_start;
   modport source(output valid, status, granted_start, input ready);
   modport sink(input valid, status, granted_start, output ready);
endinterface

[rtl/bra_front.sv]
module bra_front (
   input logic clock,
   input logic reset,
   bra_req_if.sink req,
   input logic [bra_pkg::CountW-1:0] n_bytes,
   output logic cmd_valid,
   input logic cmd_ready,
   output bra_pkg::cmd_type cmd
);
   logic [bra_pkg::SlotW-1:0] slots;
   logic [9:0] end_slot;
   bra_pkg::cmd_type q_ff [bra_pkg::QueueDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic push, pop;
   bra_pkg::cmd_type c;

   assign slots = {n_bytes, 3'b000};
   assign end_slot = {1'b0, req.slot_start} + {1'b0, req.run_length};

   always_comb begin
      c.run_length = req.run_length;
      c.slot_start = req.slot_start;
      if (req.operation == bra_pkg::OP_ALLOC) begin
         if (req.run_length == 9'd0 || req.run_length > slots) c.cls = bra_pkg::CLS_FAIL;
         else c.cls = bra_pkg::CLS_ALLOC;
      end else begin
         if (req.slot_start > slots || end_slot > 10'(slots)) c.cls = bra_pkg::CLS_REJECT;
         else c.cls = bra_pkg::CLS_FREE;
      end
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign pop = cmd_valid && cmd_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push) q_ff[wr_ptr_ff] <= c;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_nopush_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push when full");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop when empty");
endmodule

[rtl/bra_back.sv]
module bra_back (
   input logic clock,
   input logic reset,
   input logic [bra_pkg::CountW-1:0] n_bytes,
   input logic cmd_valid,
   output logic cmd_ready,
   input bra_pkg::cmd_type cmd,
   bra_rsp_if.source rsp
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_MARK = 5'b00100,
      S_CLEAR = 5'b01000,
      S_OUT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] bmp_ff [bra_pkg::MaxBytes];
   logic [bra_pkg::CountW-1:0] idx_ff, idx_in;
   logic [8:0] empty_ff, empty_in;
   logic [8:0] pos_ff, pos_in;
   logic [8:0] len_ff, len_in;
   logic [8:0] cur_ff, cur_in;
   logic [9:0] stop_ff, stop_in;
   logic [1:0] st_ff, st_in;
   logic [7:0] gs_ff, gs_in;
   logic [7:0] b;
   logic [3:0] lf, tf;
   logic [9:0] sum;
   logic wr_en;
   logic wr_val;

   assign b = bmp_ff[idx_ff[bra_pkg::ByteIdxW-1:0]];
   assign lf = bra_pkg::lead_free(b);
   assign tf = bra_pkg::trail_free(b);
   assign sum = {1'b0, empty_ff} + 10'(lf);
   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.status = st_ff;
   assign rsp.granted_start = gs_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      empty_in = empty_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      cur_in = cur_ff;
      stop_in = stop_ff;
      st_in = st_ff;
      gs_in = gs_ff;
      wr_en = 1'b0;
      wr_val = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               len_in = cmd.run_length;
               gs_in = 8'd0;
               unique case (cmd.cls)
                  bra_pkg::CLS_ALLOC: begin
                     idx_in = '0;
                     empty_in = 9'd0;
                     pos_in = 9'd0;
                     state_in = S_SCAN;
                  end
                  bra_pkg::CLS_FREE: begin
                     cur_in = cmd.slot_start;
                     stop_in = {1'b0, cmd.slot_start} + {1'b0, cmd.run_length};
                     st_in = bra_pkg::ST_FREED;
                     state_in = S_CLEAR;
                  end
                  bra_pkg::CLS_FAIL: begin
                     st_in = bra_pkg::ST_ALLOC_FAIL;
                     state_in = S_OUT;
                  end
                  default: begin
                     st_in = bra_pkg::ST_FREE_REJECT;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (idx_ff >= n_bytes || empty_ff >= len_ff) begin
               if (empty_ff >= len_ff) begin
                  cur_in = pos_ff;
                  stop_in = {1'b0, pos_ff} + {1'b0, len_ff};
                  st_in = bra_pkg::ST_ALLOCATED;
                  gs_in = pos_ff[7:0];
                  state_in = S_MARK;
               end else begin
                  st_in = bra_pkg::ST_ALLOC_FAIL;
                  state_in = S_OUT;
               end
            end else begin
               if (b == 8'd0) empty_in = empty_ff + 9'd8;
               else if (sum >= {1'b0, len_ff}) empty_in = sum[8:0];
               else begin
                  empty_in = 9'(tf);
                  pos_in = 9'({idx_ff[bra_pkg::ByteIdxW-1:0], 3'b000}) + 9'd8 - 9'(tf);
               end
               idx_in = idx_ff + bra_pkg::CountW'(1);
            end
         end
         S_MARK, S_CLEAR: begin
            if ({1'b0, cur_ff} >= stop_ff || cur_ff >= {n_bytes, 3'b000}) state_in = S_OUT;
            else begin
               wr_en = 1'b1;
               wr_val = (state_ff == S_MARK);
               cur_in = cur_ff + 9'd1;
            end
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int k = 0; k < bra_pkg::MaxBytes; k++) bmp_ff[k] <= 8'd0;
      end else begin
         state_ff <= state_in;
         if (wr_en) bmp_ff[cur_ff[bra_pkg::ByteIdxW+2:3]][3'd7 - cur_ff[2:0]] <= wr_val;
      end
      idx_ff <= idx_in;
      empty_ff <= empty_in;
      pos_ff <= pos_in;
      len_ff <= len_in;
      cur_ff <= cur_in;
      stop_ff <= stop_in;
      st_ff <= st_in;
      gs_ff <= gs_in;
   end

   a_gs: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != bra_pkg::ST_ALLOCATED |-> rsp.granted_start == 8'd0)
      else $error("grant on failure");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
      else $error("result dropped");
   a_wr: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> cur_ff < {n_bytes, 3'b000}) else $error("write past end");
endmodule

[rtl/bitmap_run_allocator_core.sv]
// channel | dir | transfer when      | payload
// req     | in  | valid && ready     | operation, run_length, slot_start
// rsp     | out | valid && ready     | status, granted_start
// csr     | in  | psel&penable&pwrite| bytes_in_use at 0x0
// Front classifies each request combinationally into a two-entry queue.
// Allocate: scan up to n bytes (n = bytes in use, capped at 32), then mark
// each slot of the run, then respond. Free: clear each slot, then respond.
// Rejects and fails respond directly.
// Reset clears the bitmap at once; back stalls on rsp, front on a full queue.
module bitmap_run_allocator_core (
   input logic clock,
   input logic reset,
   bra_req_if.sink req,
   bra_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [2:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [5:0] biu_ff;
   logic [bra_pkg::CountW-1:0] n_bytes;
   logic cmd_valid, cmd_ready;
   bra_pkg::cmd_type cmd;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == bra_pkg::REG_BYTES_IN_USE) ? {26'd0, biu_ff} : 32'd0;
   assign n_bytes = (biu_ff > 6'(bra_pkg::MaxBytes)) ? bra_pkg::CountW'(bra_pkg::MaxBytes)
                                                     : bra_pkg::CountW'(biu_ff);

   always_ff @(posedge clock) begin
      if (reset) biu_ff <= 6'd32;
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr[2] == bra_pkg::REG_BYTES_IN_USE)
         biu_ff <= csr_pwdata[5:0];
   end

   bra_front u_front (.clock, .reset, .req, .n_bytes, .cmd_valid, .cmd_ready, .cmd);
   bra_back u_back (.clock, .reset, .n_bytes, .cmd_valid, .cmd_ready, .cmd, .rsp);
endmodule
